// ===== hdl/spq_pkg.sv =====
// shared types and codes for the stable priority task queue
package spq_pkg;

  localparam int PRIO_BITS   = 3;
  localparam int PRIO_LEVELS = 1 << PRIO_BITS;
  localparam int ID_WIDTH    = 32;
  localparam int TOTAL_BITS  = 7;

  localparam logic       OP_PUSH = 1'b0;
  localparam logic       OP_POP  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                 operation;
    logic [ID_WIDTH-1:0]  task_id;
    logic [PRIO_BITS-1:0] priority_req;
  } req_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [ID_WIDTH-1:0]   head_id;
    logic [PRIO_BITS-1:0]  head_priority;
    logic [TOTAL_BITS-1:0] entry_total;
    logic                  is_empty;
  } rsp_item_t;

endpackage

// ===== hdl/spq_stream_if.sv =====
// valid/ready stream channel carrying one item per transfer
interface spq_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/stable_priority_task_queue_core.sv =====
// stable priority task queue: per-priority fifos held in one ram
//
// Entries are kept as eight first-in first-out lists, one per priority level, in a single
// ram addressed by {priority, pointer}; head and tail pointers and per-level counts sit in
// registers. A pop serves the oldest entry of the highest non-empty level, which is the same
// order as a sorted array where equal priorities keep arrival order. Total capacity is
// QUEUE_DEPTH entries shared by all levels; a push when full reports status full, a pop when
// empty reports status empty, both leaving the queue unchanged. A push or a flagged request
// produces its result in the cycle after its transfer; a successful pop first reads the head
// entry from the ram, whose read data is registered, and loads its result in state S_READ.
// One request is in flight at a time, and the next request is taken as soon as the result
// register is free or being drained. Reset needs no clearing pass.
module stable_priority_task_queue_core #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_BITS     = 32
) (
  input logic clk,
  input logic rst,
  spq_stream_if.sink   req,
  spq_stream_if.source rsp
);
  import spq_pkg::*;

  localparam int PtrBits   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CountBits = $clog2(QUEUE_DEPTH + 1);
  localparam int StoreBits = (ID_BITS < ID_WIDTH) ? ID_BITS : ID_WIDTH;
  localparam int AddrBits  = PRIO_BITS + PtrBits;
  localparam int RamDepth  = PRIO_LEVELS * (1 << PtrBits);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                 state;
  logic [PtrBits-1:0]   head_ptr    [PRIO_LEVELS];
  logic [PtrBits-1:0]   tail_ptr    [PRIO_LEVELS];
  logic [CountBits-1:0] class_count [PRIO_LEVELS];
  logic [CountBits-1:0] occupancy;
  logic [PRIO_BITS-1:0] pop_prio;
  logic                 rsp_valid;
  rsp_item_t            rsp_data;

  logic                 accept;
  logic                 rsp_load;
  logic                 full;
  logic                 push_ok;
  logic                 pop_ok;
  logic [PRIO_BITS-1:0] sel_prio;
  logic [PRIO_BITS-1:0] push_prio;
  logic [CountBits-1:0] occ_inc;
  logic [CountBits-1:0] occ_dec;
  logic                 ram_we;
  logic [AddrBits-1:0]  ram_waddr;
  logic [AddrBits-1:0]  ram_raddr;
  logic [StoreBits-1:0] ram_wdata;
  logic [StoreBits-1:0] ram_rdata;

  function automatic logic [PtrBits-1:0] ptr_advance(input logic [PtrBits-1:0] p);
    logic [PtrBits-1:0] r;
    if (p == PtrBits'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PtrBits'(1);
    end
    return r;
  endfunction

  // highest level that holds an entry
  always_comb begin
    sel_prio = '0;
    for (int i = 0; i < PRIO_LEVELS; i++) begin
      if (class_count[i] != '0) begin
        sel_prio = PRIO_BITS'(i);
      end
    end
  end

  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign push_prio = req.data.priority_req;
  assign full      = (occupancy == CountBits'(QUEUE_DEPTH));
  assign push_ok   = (req.data.operation == OP_PUSH) && !full;
  assign pop_ok    = (req.data.operation == OP_POP) && (occupancy != '0);
  assign occ_inc   = occupancy + CountBits'(1);
  assign occ_dec   = occupancy - CountBits'(1);

  // a new result is loaded on any transfer other than a successful pop or when the head read returns
  assign rsp_load  = (state == S_READ) || (accept && !pop_ok);

  assign ram_we    = accept && push_ok;
  assign ram_waddr = {push_prio, tail_ptr[push_prio]};
  assign ram_wdata = StoreBits'(req.data.task_id);
  assign ram_raddr = {sel_prio, head_ptr[sel_prio]};

  spq_ram #(
    .WIDTH (StoreBits),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      occupancy <= '0;
      for (int i = 0; i < PRIO_LEVELS; i++) begin
        head_ptr[i]    <= '0;
        tail_ptr[i]    <= '0;
        class_count[i] <= '0;
      end
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (push_ok) begin
              tail_ptr[push_prio]    <= ptr_advance(tail_ptr[push_prio]);
              class_count[push_prio] <= class_count[push_prio] + CountBits'(1);
              occupancy              <= occ_inc;
              rsp_data.status        <= STATUS_OK;
              rsp_data.head_id       <= '0;
              rsp_data.head_priority <= '0;
              rsp_data.entry_total   <= TOTAL_BITS'(occ_inc);
              rsp_data.is_empty      <= 1'b0;
            end else if (pop_ok) begin
              // result waits for the ram read of the head entry
              head_ptr[sel_prio]    <= ptr_advance(head_ptr[sel_prio]);
              class_count[sel_prio] <= class_count[sel_prio] - CountBits'(1);
              occupancy             <= occ_dec;
              pop_prio              <= sel_prio;
              state                 <= S_READ;
            end else begin
              rsp_data.status        <= (req.data.operation == OP_PUSH) ? STATUS_FULL
                                                                        : STATUS_EMPTY;
              rsp_data.head_id       <= '0;
              rsp_data.head_priority <= '0;
              rsp_data.entry_total   <= TOTAL_BITS'(occupancy);
              rsp_data.is_empty      <= (occupancy == '0);
            end
          end
        end
        S_READ: begin
          rsp_data.status        <= STATUS_OK;
          rsp_data.head_id       <= ID_WIDTH'(ram_rdata);
          rsp_data.head_priority <= pop_prio;
          rsp_data.entry_total   <= TOTAL_BITS'(occupancy);
          rsp_data.is_empty      <= (occupancy == '0);
          state                  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;
endmodule

// ===== hdl/spq_ram.sv =====
// generic single-write, single-read ram with registered read data
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
